FILE: rtl/core/bsm_pkg.sv
// Shared constants, types and Booth decode for the Booth signed multiplier.
`timescale 1ns / 1ps

package bsm_pkg;

	localparam int unsigned WIDTH_DEFAULT = 8;

	typedef enum logic [1:0] {
		BOOTH_NOP = 2'd0,
		BOOTH_ADD = 2'd1,
		BOOTH_SUB = 2'd2
	} booth_op_t;

	// radix-2 recoding of the current multiplier bit and the one below it
	function automatic booth_op_t booth_decode(input logic cur, input logic prev);
		booth_op_t op;
		unique case ({cur, prev})
			2'b10: begin
				op = BOOTH_SUB;
			end
			2'b01: begin
				op = BOOTH_ADD;
			end
			default: begin
				op = BOOTH_NOP;
			end
		endcase
		return op;
	endfunction

endpackage

FILE: rtl/core/bsm_cell.sv
// One Booth step cell: adds, subtracts or passes on the shifted multiplicand and registers the item.
`timescale 1ns / 1ps

module bsm_cell #(
	parameter int unsigned WIDTH = bsm_pkg::WIDTH_DEFAULT,
	parameter int unsigned STEP  = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [WIDTH-1:0]     in_mcand,
	input  logic [WIDTH-1:0]     in_mplier,
	input  logic [2*WIDTH-1:0]   in_acc,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [WIDTH-1:0]     out_mcand,
	output logic [WIDTH-1:0]     out_mplier,
	output logic [2*WIDTH-1:0]   out_acc
);
	import bsm_pkg::*;

	localparam int unsigned PREV_IDX = (STEP == 0) ? 0 : STEP - 1;

	logic               valid_q;
	logic [WIDTH-1:0]   mcand_q;
	logic [WIDTH-1:0]   mplier_q;
	logic [2*WIDTH-1:0] acc_q;
	logic               prev;
	logic [2*WIDTH-1:0] term;
	logic [2*WIDTH-1:0] acc_next;
	booth_op_t          op;

	assign prev = (STEP == 0) ? 1'b0 : in_mplier[PREV_IDX];
	assign term = {{WIDTH{in_mcand[WIDTH-1]}}, in_mcand} << STEP;
	assign op   = booth_decode(in_mplier[STEP], prev);

	always_comb begin
		unique case (op)
			BOOTH_ADD: begin
				acc_next = in_acc + term;
			end
			BOOTH_SUB: begin
				acc_next = in_acc - term;
			end
			default: begin
				acc_next = in_acc;
			end
		endcase
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mcand_q  <= in_mcand;
			mplier_q <= in_mplier;
			acc_q    <= acc_next;
		end
	end

	assign out_valid  = valid_q;
	assign out_mcand  = mcand_q;
	assign out_mplier = mplier_q;
	assign out_acc    = acc_q;

endmodule

FILE: rtl/core/booth_signed_multiplier_core.sv
// Top level of the radix-2 Booth signed multiplier: a chain of WIDTH step cells.
`timescale 1ns / 1ps

// Signed two's-complement multiplier giving the exact 2*WIDTH-bit product.
// The operands pass through a chain of WIDTH cells, one Booth step per cell,
// and each item's partial product is registered in every cell in turn; a new
// item is accepted every cycle while in_ready is high. The last cell's register
// drives the output; when out_ready is low, cells fill up behind it and in_ready
// drops only once the whole chain holds items.

module booth_signed_multiplier_core #(
	parameter int unsigned WIDTH = bsm_pkg::WIDTH_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [WIDTH-1:0]   multiplicand,
	input  logic signed [WIDTH-1:0]   multiplier,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [2*WIDTH-1:0] product
);

	logic               valid [WIDTH+1];
	logic               ready [WIDTH+1];
	logic [WIDTH-1:0]   mcand [WIDTH+1];
	logic [WIDTH-1:0]   mplier[WIDTH+1];
	logic [2*WIDTH-1:0] acc   [WIDTH+1];

	assign valid[0]  = in_valid;
	assign in_ready  = ready[0];
	assign mcand[0]  = multiplicand;
	assign mplier[0] = multiplier;
	assign acc[0]    = '0;

	for (genvar i = 0; i < WIDTH; i++) begin : g_cell
		bsm_cell #(
			.WIDTH(WIDTH),
			.STEP (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid[i]),
			.in_ready  (ready[i]),
			.in_mcand  (mcand[i]),
			.in_mplier (mplier[i]),
			.in_acc    (acc[i]),
			.out_valid (valid[i+1]),
			.out_ready (ready[i+1]),
			.out_mcand (mcand[i+1]),
			.out_mplier(mplier[i+1]),
			.out_acc   (acc[i+1])
		);
	end

	assign ready[WIDTH] = out_ready;
	assign out_valid    = valid[WIDTH];
	assign product      = acc[WIDTH];

endmodule
